@@ rtl/core/rgbhsi_pkg.sv @@
`timescale 1ns / 1ps
package rgbhsi_pkg;

    localparam int XW = 28;
    localparam int ZW = 26;
    localparam int STEPS = 17;
    localparam int RW = 19;
    localparam int DW = 11;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 neg_base;
        logic                 spec;
        logic [7:0]           spec_hue;
        logic                 nz;
        logic [RW-1:0]        rem;
        logic [DW-1:0]        dv;
        logic [7:0]           q;
        logic [7:0]           inten;
    } cell_data_t;

    function automatic logic signed [ZW-1:0] atan_q16(input int i);
        logic signed [ZW-1:0] a;
        case (i)
            0: a = 26'sd2949120;
            1: a = 26'sd1740967;
            2: a = 26'sd919879;
            3: a = 26'sd466945;
            4: a = 26'sd234379;
            5: a = 26'sd117304;
            6: a = 26'sd58666;
            7: a = 26'sd29335;
            8: a = 26'sd14668;
            9: a = 26'sd7334;
            10: a = 26'sd3667;
            11: a = 26'sd1833;
            12: a = 26'sd917;
            13: a = 26'sd458;
            14: a = 26'sd229;
            15: a = 26'sd115;
            16: a = 26'sd57;
            default: a = '0;
        endcase
        return a;
    endfunction

    function automatic logic signed [XW-1:0] shr_tz(input logic signed [XW-1:0] v,
                                                    input logic [4:0] s);
        logic signed [XW-1:0] r;
        if (v < 0)
            r = -((-v) >>> s);
        else
            r = v >>> s;
        return r;
    endfunction

endpackage

@@ rtl/core/rgbhsi_cell.sv @@
`timescale 1ns / 1ps
module rgbhsi_cell #(
    parameter int IDX = 0
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  rgbhsi_pkg::cell_data_t  in_data,
    output logic                    out_valid,
    output rgbhsi_pkg::cell_data_t  out_data
);

    localparam int QB = (IDX < 8) ? 7 - IDX : 0;

    rgbhsi_pkg::cell_data_t data_next;
    rgbhsi_pkg::cell_data_t data_reg;
    logic                   valid_reg;

    always_comb
    begin
        logic signed [rgbhsi_pkg::XW-1:0] xs;
        logic signed [rgbhsi_pkg::XW-1:0] ys;
        logic [rgbhsi_pkg::RW-1:0]        dsh;
        data_next = in_data;
        xs = rgbhsi_pkg::shr_tz(in_data.x, 5'(IDX));
        ys = rgbhsi_pkg::shr_tz(in_data.y, 5'(IDX));
        dsh = '0;
        if (!in_data.y[rgbhsi_pkg::XW-1])
        begin
            data_next.x = in_data.x + ys;
            data_next.y = in_data.y - xs;
            data_next.z = in_data.z + rgbhsi_pkg::atan_q16(IDX);
        end
        else
        begin
            data_next.x = in_data.x - ys;
            data_next.y = in_data.y + xs;
            data_next.z = in_data.z - rgbhsi_pkg::atan_q16(IDX);
        end
        if (IDX < 8)
        begin
            dsh = rgbhsi_pkg::RW'(in_data.dv) << 3'(QB);
            if (in_data.rem >= dsh)
            begin
                data_next.rem = in_data.rem - dsh;
                data_next.q[3'(QB)] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

@@ rtl/core/rgb_to_hsi_pixel_core.sv @@
`timescale 1ns / 1ps
// RGB to HSI pixel converter, one pixel per beat on each side.
// The slave channel takes a pixel: tdata holds blue, green and red.
// The master channel returns hue_half, saturation and intensity in tdata.
// The pixel runs through an entry register, a row of 17 CORDIC cells and
// an output register before it leaves on the master channel. The first
// eight cells also resolve one saturation quotient bit each. Throughput is
// one pixel per clock while the receiver takes beats.
// When the receiver stalls a valid output, the whole pipeline holds and
// s_axis_tready drops in the same cycle, so no beat is lost or repeated.
// Bubbles in the pipeline are not squeezed out during a stall.
// Reset clears all valid flags; the pipeline is empty and ready afterward.
module rgb_to_hsi_pixel_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // blue, green, red
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // hue_half, saturation, intensity
);

    localparam int N = rgbhsi_pkg::STEPS;

    logic en;
    logic [N:0] vld;
    rgbhsi_pkg::cell_data_t dat [N+1];
    rgbhsi_pkg::cell_data_t entry_next;
    logic entry_valid_reg;
    rgbhsi_pkg::cell_data_t entry_reg;
    logic out_valid_reg;
    logic [23:0] out_reg;
    logic [23:0] out_next;

    assign en = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    always_comb
    begin
        logic [7:0] b, g, r;
        logic [9:0] sum;
        logic [7:0] mn;
        logic signed [10:0] dx;
        logic signed [8:0] dy;
        logic signed [26:0] yp;
        logic signed [rgbhsi_pkg::XW-1:0] x0, y0;
        logic [10:0] t;
        logic [24:0] ip;
        b = s_axis_tdata[7:0];
        g = s_axis_tdata[15:8];
        r = s_axis_tdata[23:16];
        sum = 10'(r) + 10'(g) + 10'(b);
        mn = r;
        if (g < mn)
            mn = g;
        if (b < mn)
            mn = b;
        dx = $signed({2'b00, r, 1'b0}) - $signed({3'b000, g}) - $signed({3'b000, b});
        dy = $signed({1'b0, g}) - $signed({1'b0, b});
        yp = dy * 18'sd113512;
        x0 = {{(rgbhsi_pkg::XW-27){dx[10]}}, dx, 16'h0000};
        y0 = rgbhsi_pkg::XW'(yp);
        entry_next = '0;
        entry_next.neg_base = x0[rgbhsi_pkg::XW-1];
        entry_next.x = x0[rgbhsi_pkg::XW-1] ? -x0 : x0;
        entry_next.y = x0[rgbhsi_pkg::XW-1] ? -y0 : y0;
        entry_next.spec = (dy == 9'sd0);
        entry_next.spec_hue = dx[10] ? 8'd90 : 8'd0;
        entry_next.nz = (sum != 10'd0);
        entry_next.rem = 19'(10'd510 * 19'(sum - 10'(3 * mn))) + 19'(sum);
        entry_next.dv = {sum, 1'b0};
        t = {sum, 1'b0} + 11'd3;
        ip = 25'(t) * 25'd10923;
        entry_next.inten = ip[23:16];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            entry_valid_reg <= 1'b0;
        else if (en)
            entry_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            entry_reg <= entry_next;
    end

    assign vld[0] = entry_valid_reg;
    assign dat[0] = entry_reg;

    genvar i;
    generate
        for (i = 0; i < N; i++)
        begin : g_cell
            rgbhsi_cell #(.IDX(i)) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .en       (en),
                .in_valid (vld[i]),
                .in_data  (dat[i]),
                .out_valid(vld[i+1]),
                .out_data (dat[i+1])
            );
        end
    endgenerate

    always_comb
    begin
        logic signed [26:0] h;
        logic [26:0] hr;
        logic [7:0] hue;
        rgbhsi_pkg::cell_data_t d;
        d = dat[N];
        h = 27'(d.z);
        if (d.neg_base)
            h = h + 27'sd11796480;
        if (h < 0)
            h = h + 27'sd23592960;
        if (h >= 27'sd23592960)
            h = h - 27'sd23592960;
        hr = (27'(h) + 27'd65536) >> 17;
        hue = (hr > 27'd180) ? 8'd180 : hr[7:0];
        if (d.spec)
            hue = d.spec_hue;
        out_next = {d.inten, (d.nz ? d.q : 8'd0), hue};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= vld[N];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_reg <= out_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;

`ifndef SYNTHESIS
    a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("ready does not follow the output stall");
    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[7:0] <= 8'd180))
        else $error("hue out of range");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");
`endif

endmodule

@@ sim/rgb_to_hsi_pixel_checker.sv @@
`timescale 1ns / 1ps
module rgb_to_hsi_pixel_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,
    output int          fail_count,
    output int          pending_count
);

    typedef struct packed {
        logic [7:0] intensity;
        logic [7:0] saturation;
        logic [7:0] hue_half;
    } hsi_t;

    localparam longint SQRT3_FIX = 113512;
    localparam longint ONE_DEG = 65536;

    hsi_t hsi_queue[$];

    function automatic longint trunc_shift(longint v, int s);
        if (v < 0)
            return -((-v) >>> s);
        return v >>> s;
    endfunction

    function automatic longint arctan_deg(int i);
        longint tbl[17] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                            29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57};
        return tbl[i];
    endfunction

    function automatic logic [7:0] half_hue(longint r, longint g, longint b);
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        longint h;
        x = (2 * r - g - b) * 65536;
        y = (g - b) * SQRT3_FIX;
        z = 0;
        h = 0;
        if (y == 0)
            return (x < 0) ? 8'd90 : 8'd0;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            h = 180 * ONE_DEG;
        end
        for (int i = 0; i < 17; i++)
        begin
            xs = trunc_shift(x, i);
            ys = trunc_shift(y, i);
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + arctan_deg(i);
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - arctan_deg(i);
            end
        end
        h = h + z;
        if (h < 0)
            h = h + 360 * ONE_DEG;
        if (h >= 360 * ONE_DEG)
            h = h - 360 * ONE_DEG;
        h = (h + 65536) >>> 17;
        if (h > 180)
            h = 180;
        return h[7:0];
    endfunction

    function automatic hsi_t convert_pixel(logic [23:0] pix);
        hsi_t o;
        longint b;
        longint g;
        longint r;
        longint sum;
        longint mn;
        longint sat;
        longint inten;
        b = pix[7:0];
        g = pix[15:8];
        r = pix[23:16];
        sum = r + g + b;
        mn = r;
        if (g < mn)
            mn = g;
        if (b < mn)
            mn = b;
        sat = 0;
        if (sum != 0)
            sat = (510 * (sum - 3 * mn) + sum) / (2 * sum);
        if (sat > 255)
            sat = 255;
        inten = (2 * sum + 3) / 6;
        o.hue_half = half_hue(r, g, b);
        o.saturation = sat[7:0];
        o.intensity = inten[7:0];
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        hsi_t want;
        hsi_t got;
        if (!rst_n)
        begin
            fail_count <= 0;
            pending_count <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                hsi_queue.push_back(convert_pixel(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata;
                if (hsi_queue.size() == 0)
                begin
                    $display("%0t: unexpected beat, expected none, actual %h", $time, got);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = hsi_queue.pop_front();
                    if (want.hue_half != got.hue_half || want.saturation != got.saturation
                        || want.intensity != got.intensity)
                    begin
                        $display("%0t: expected h=%0d s=%0d i=%0d, actual h=%0d s=%0d i=%0d",
                                 $time, want.hue_half, want.saturation, want.intensity,
                                 got.hue_half, got.saturation, got.intensity);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending_count <= hsi_queue.size();
        end
    end

endmodule

@@ sim/tb_rgb_to_hsi_pixel_core.sv @@
`timescale 1ns / 1ps
module tb_rgb_to_hsi_pixel_core;

    localparam int IDLE_LIMIT = 20000;
    localparam int HOLD_LEN = 200;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    int          fail_count;
    int          pending_count;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_cycles;
    int          quiet_cycles;
    logic        hold_req;
    logic        hold_done;

    rgb_to_hsi_pixel_core dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    rgb_to_hsi_pixel_checker checker_i (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .fail_count(fail_count),
        .pending_count(pending_count)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_cycles <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_req && !hold_done)
        begin
            m_axis_tready <= 1'b0;
            if (hold_cycles >= HOLD_LEN - 1)
                hold_done <= 1'b1;
            hold_cycles <= hold_cycles + 1;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("rgb_to_hsi_pixel_core: mismatch");
            $finish;
        end
    end

    task automatic send_pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {r, g, b};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic send_random(input int count);
        logic [7:0] b;
        logic [7:0] g;
        logic [7:0] r;
        for (int i = 0; i < count; i++)
        begin
            b = 8'($urandom);
            g = 8'($urandom);
            r = 8'($urandom);
            case ($urandom_range(9))
                0: g = b;
                1: begin g = r; b = r; end
                2: begin b = 8'($urandom_range(3)); g = 8'(b + $urandom_range(2)); end
                3: r = 8'(g + $urandom_range(2) - 1);
                default: ;
            endcase
            send_pixel(b, g, r);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_req = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd77, 8'd77, 8'd77);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd40, 8'd40, 8'd200);
        send_pixel(8'd200, 8'd200, 8'd40);
        send_pixel(8'd1, 8'd0, 8'd255);
        send_pixel(8'd2, 8'd0, 8'd255);
        send_pixel(8'd0, 8'd1, 8'd0);
        send_pixel(8'd1, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd1, 8'd2, 8'd0);
        send_pixel(8'd170, 8'd85, 8'd0);
        send_pixel(8'd128, 8'd127, 8'd128);

        send_random(450);
        send_idle_pct = 53;
        send_random(450);
        send_idle_pct = 0;
        recv_stall_pct = 53;
        send_random(450);
        send_idle_pct = 31;
        recv_stall_pct = 31;
        send_random(400);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_req <= 1'b1;
        send_random(180);

        s_axis_tvalid <= 1'b0;
        while (pending_count > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("rgb_to_hsi_pixel_core: match");
        else
            $display("rgb_to_hsi_pixel_core: mismatch");
        $finish;
    end

endmodule
